/* rtl/core/dtls_unified_header_parser_macros.svh */
// Assertion macros for the DTLS unified header parser.
// Expects clk and rst_n in the scope of use; define NO_ASSERTIONS to drop them.
`ifndef DTLS_UNIFIED_HEADER_PARSER_MACROS_SVH
`define DTLS_UNIFIED_HEADER_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DUHP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define DUHP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DUHP_ASSERT_IMP(lbl, ante, cons, msg)

`define DUHP_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/dtls_uhp_pkg.sv */
// Shared types, constants and header layout function for the DTLS unified
// header parser. No dependencies.
package dtls_uhp_pkg;

    localparam logic [7:0]  FIXED_MASK = 8'hE0;
    localparam logic [7:0]  FIXED_VAL  = 8'h20;
    localparam int          CID_BIT    = 4;
    localparam int          SEQ16_BIT  = 3;
    localparam int          LEN_BIT    = 2;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int REG_LSB  = 2;

    typedef enum logic [0:0] {
        REG_CID_LENGTH = 1'b0
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_UNIFIED = 3'd1,
        ST_CID_UNKNOWN = 3'd2,
        ST_TRUNCATED   = 3'd3,
        ST_BAD_LENGTH  = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_beat_t;

    typedef struct packed {
        status_t     status;
        logic        has_cid;
        logic        seq_is_16bit;
        logic        has_length;
        logic [1:0]  epoch_low_bits;
        logic [7:0]  cid_length_out;
        logic [15:0] seq_number;
        logic [15:0] record_length;
        logic [8:0]  payload_offset;
    } result_beat_t;

    // Datagram summary handed from the byte tracker to the checker
    typedef struct packed {
        logic [7:0]  flags;
        logic [15:0] total;
        logic [15:0] seq;
        logic [15:0] len;
    } summary_t;

    typedef struct packed {
        logic [8:0] seq_pos;
        logic [8:0] len_pos;
        logic [8:0] need;
    } layout_t;

    function automatic layout_t hdr_layout(input logic [7:0] flags, input logic [7:0] cid);
        layout_t    lay;
        logic [8:0] cid9;
        cid9        = flags[CID_BIT] ? {1'b0, cid} : 9'd0;
        lay.seq_pos = 9'd1 + cid9;
        lay.len_pos = lay.seq_pos + (flags[SEQ16_BIT] ? 9'd2 : 9'd1);
        lay.need    = lay.len_pos + (flags[LEN_BIT] ? 9'd2 : 9'd0);
        return lay;
    endfunction

endpackage

/* rtl/core/dtls_uhp_regs.sv */
// APB-style configuration register (connection id length).
// Depends on dtls_uhp_pkg.
module dtls_uhp_regs
    import dtls_uhp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [7:0]        cid_length
);

    logic [7:0] cid_length_reg;
    logic [7:0] cid_length_next;
    logic       sel_cid;

    assign sel_cid = (reg_idx_t'(paddr[ADDR_W-1:REG_LSB]) == REG_CID_LENGTH);

    always_comb
    begin
        cid_length_next = cid_length_reg;
        if (psel && penable && pwrite && sel_cid)
        begin
            cid_length_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cid_length_reg <= 8'd0;
        end
        else
        begin
            cid_length_reg <= cid_length_next;
        end
    end

    assign prdata     = sel_cid ? {{(DATA_W-8){1'b0}}, cid_length_reg} : '0;
    assign pready     = 1'b1;
    assign cid_length = cid_length_reg;

endmodule

/* rtl/core/dtls_uhp_track.sv */
// Byte tracker: counts datagram bytes, keeps the flags byte and shifts in the
// sequence and length fields; registers a summary on the last beat. Uses dtls_uhp_pkg.
module dtls_uhp_track
    import dtls_uhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] cid_length,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  byte_beat_t byte_data,
    output logic       sum_valid,
    input  logic       sum_ready,
    output summary_t   sum_data
);

    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] len_reg, len_next;
    logic        sum_valid_reg, sum_valid_next;
    summary_t    sum_reg, sum_next;

    layout_t     lay;
    logic        accept;
    logic        first;
    logic        in_seq;
    logic        in_len;
    logic [7:0]  flags_upd;
    logic [15:0] count_upd;
    logic [15:0] seq_upd;
    logic [15:0] len_upd;

    assign byte_ready = !sum_valid_reg || sum_ready;
    assign accept     = byte_valid && byte_ready;
    assign first      = (byte_count_reg == 16'd0);
    assign lay        = hdr_layout(flags_reg, cid_length);

    always_comb
    begin
        in_seq    = !first && (byte_count_reg >= {7'd0, lay.seq_pos})
                           && (byte_count_reg <  {7'd0, lay.len_pos});
        in_len    = !first && flags_reg[LEN_BIT]
                           && (byte_count_reg >= {7'd0, lay.len_pos})
                           && (byte_count_reg <  {7'd0, lay.need});
        flags_upd = first ? byte_data.data_byte : flags_reg;
        seq_upd   = in_seq ? {seq_reg[7:0], byte_data.data_byte} : seq_reg;
        len_upd   = in_len ? {len_reg[7:0], byte_data.data_byte} : len_reg;
        count_upd = (byte_count_reg == COUNT_MAX) ? byte_count_reg : byte_count_reg + 16'd1;

        byte_count_next = byte_count_reg;
        flags_next      = flags_reg;
        seq_next        = seq_reg;
        len_next        = len_reg;
        sum_next        = sum_reg;
        sum_valid_next  = sum_valid_reg && !sum_ready;

        if (accept)
        begin
            if (byte_data.last_byte)
            begin
                byte_count_next = 16'd0;
                flags_next      = 8'd0;
                seq_next        = 16'd0;
                len_next        = 16'd0;
                sum_next.flags  = flags_upd;
                sum_next.total  = count_upd;
                sum_next.seq    = seq_upd;
                sum_next.len    = len_upd;
                sum_valid_next  = 1'b1;
            end
            else
            begin
                byte_count_next = count_upd;
                flags_next      = flags_upd;
                seq_next        = seq_upd;
                len_next        = len_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 16'd0;
            flags_reg      <= 8'd0;
            seq_reg        <= 16'd0;
            len_reg        <= 16'd0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            flags_reg      <= flags_next;
            seq_reg        <= seq_next;
            len_reg        <= len_next;
            sum_valid_reg  <= sum_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum_valid = sum_valid_reg;
    assign sum_data  = sum_reg;

endmodule

/* rtl/core/dtls_uhp_check.sv */
// Header checker: validates a datagram summary, builds the result beat and
// holds it in the output register. Uses dtls_uhp_pkg and the macros header.
`include "dtls_unified_header_parser_macros.svh"

module dtls_uhp_check
    import dtls_uhp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   cid_length,
    input  logic         sum_valid,
    output logic         sum_ready,
    input  summary_t     sum_data,
    output logic         result_valid,
    input  logic         result_ready,
    output result_beat_t result_data
);

    logic         result_valid_reg, result_valid_next;
    result_beat_t result_reg, result_next;

    layout_t      lay;
    logic [15:0]  need16;
    logic [15:0]  avail;
    logic [15:0]  length;
    status_t      status;
    logic         load;

    assign sum_ready = !result_valid_reg || result_ready;
    assign load      = sum_valid && sum_ready;
    assign lay       = hdr_layout(sum_data.flags, cid_length);
    assign need16    = {7'd0, lay.need};
    assign avail     = sum_data.total - need16;

    always_comb
    begin
        status = ST_OK;
        length = avail;
        if ((sum_data.flags & FIXED_MASK) != FIXED_VAL)
        begin
            status = ST_NOT_UNIFIED;
        end
        else if (sum_data.flags[CID_BIT] && (cid_length == 8'd0))
        begin
            status = ST_CID_UNKNOWN;
        end
        else if (sum_data.total < need16)
        begin
            status = ST_TRUNCATED;
        end
        else if (sum_data.flags[LEN_BIT])
        begin
            length = sum_data.len;
            if (sum_data.len > avail)
            begin
                status = ST_BAD_LENGTH;
            end
        end

        result_next        = '0;
        result_next.status = status;
        if (status == ST_OK)
        begin
            result_next.has_cid         = sum_data.flags[CID_BIT];
            result_next.seq_is_16bit    = sum_data.flags[SEQ16_BIT];
            result_next.has_length      = sum_data.flags[LEN_BIT];
            result_next.epoch_low_bits  = sum_data.flags[1:0];
            result_next.cid_length_out  = sum_data.flags[CID_BIT] ? cid_length : 8'd0;
            result_next.seq_number      = sum_data.seq;
            result_next.record_length   = length;
            result_next.payload_offset  = lay.need;
        end

        result_valid_next = load ? 1'b1 : (result_valid_reg && !result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // error beats carry status only
    `DUHP_ASSERT_IMP(a_err_fields_zero,
        result_valid_reg && (result_reg.status != ST_OK),
        result_reg[53:0] == '0, "error result carries non-zero fields")

    `DUHP_ASSERT_IMP(a_ok_offset_range,
        result_valid_reg && (result_reg.status == ST_OK),
        (result_reg.payload_offset >= 9'd2) && (result_reg.payload_offset <= 9'd260),
        "payload offset out of range")

    `DUHP_ASSERT_IMP(a_ok_cid_consistent,
        result_valid_reg && (result_reg.status == ST_OK),
        result_reg.has_cid == (result_reg.cid_length_out != 8'd0),
        "cid flag and cid length disagree")

    `DUHP_ASSERT_NXT(a_load_sets_valid, load, result_valid_reg,
        "loaded result not presented")

endmodule

/* rtl/core/dtls_unified_header_parser.sv */
// DTLS 1.3 unified header parser, top level.
// Instantiates dtls_uhp_regs, dtls_uhp_track and dtls_uhp_check; uses dtls_uhp_pkg.
//
// Usage:
//   byte channel   : one datagram byte per beat (data_byte, last_byte), valid/ready.
//   result channel : one beat per datagram, issued for the beat with last_byte set.
//   config port    : APB-style, cid_length at byte address 0, pready tied high.
// Path: the result for an accepted last byte is registered in the summary register,
//   then in the output register, where it waits for result_ready.
// Throughput: one byte per cycle, sustained, back-to-back datagrams included, while
//   result_ready is high; each register stage frees as soon as its content moves on.
// Reset: clears the byte counter, flags and field accumulators, both valid
//   flags and cid_length; the block accepts bytes as soon as reset is released.
// Stall: while the result beat waits, the summary stage still takes one more
//   last byte; with both stages full byte_ready drops until result_ready.
// Byte counter saturates at 65535 within a datagram.
module dtls_unified_header_parser
    import dtls_uhp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  byte_beat_t        byte_data,
    output logic              result_valid,
    input  logic              result_ready,
    output result_beat_t      result_data
);

    logic [7:0] cid_length;
    logic       sum_valid;
    logic       sum_ready;
    summary_t   sum_data;

    dtls_uhp_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cid_length (cid_length)
    );

    dtls_uhp_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .cid_length (cid_length),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .sum_valid  (sum_valid),
        .sum_ready  (sum_ready),
        .sum_data   (sum_data)
    );

    dtls_uhp_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cid_length   (cid_length),
        .sum_valid    (sum_valid),
        .sum_ready    (sum_ready),
        .sum_data     (sum_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

/* tb/tb_dtls_unified_header_parser.sv */
`timescale 1ns / 100ps
// Self-checking bench for dtls_unified_header_parser: a directed datagram table, then
// random datagram phases over several cid_length settings, every result beat checked.
// Depends on dtls_uhp_pkg and the parser RTL only.
module tb_dtls_unified_header_parser;
    import dtls_uhp_pkg::*;

    typedef struct packed {
        logic [7:0]  cid;
        logic [7:0]  flags;
        logic [16:0] nbytes;
        logic [15:0] lenval;
        logic        typed;
        status_t     st;
    } dgram_row_t;

    localparam int N_ROWS      = 21;
    localparam int HOLD_CYCLES = 60;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              byte_valid;
    logic              byte_ready;
    byte_beat_t        byte_data;
    logic              result_valid;
    logic              result_ready;
    result_beat_t      result_data;

    logic [7:0]   cid_cfg;
    logic [15:0]  dg_count;
    logic [7:0]   dg_flags;
    logic [15:0]  seq_sr;
    logic [15:0]  len_sr;

    result_beat_t pending_headers [$];
    int           mismatches;
    bit           quiet;
    bit           hold_off_req;
    int           hold_left;
    int           phase_bytes;
    int           phase_headers;

    dgram_row_t plan [N_ROWS] = '{
        '{8'd0,   8'h20, 17'd2,     16'h0000, 1'b0, ST_OK},
        '{8'd0,   8'h23, 17'd3,     16'h0000, 1'b0, ST_OK},
        '{8'd0,   8'h00, 17'd1,     16'h0000, 1'b1, ST_NOT_UNIFIED},
        '{8'd0,   8'hE0, 17'd4,     16'h0000, 1'b1, ST_NOT_UNIFIED},
        '{8'd0,   8'h10, 17'd3,     16'h0000, 1'b1, ST_NOT_UNIFIED},
        '{8'd0,   8'h30, 17'd5,     16'h0000, 1'b1, ST_CID_UNKNOWN},
        '{8'd0,   8'h38, 17'd1,     16'h0000, 1'b1, ST_CID_UNKNOWN},
        '{8'd0,   8'h20, 17'd1,     16'h0000, 1'b1, ST_TRUNCATED},
        '{8'd0,   8'h2C, 17'd4,     16'h0000, 1'b1, ST_TRUNCATED},
        '{8'd0,   8'h2C, 17'd5,     16'h0000, 1'b0, ST_OK},
        '{8'd0,   8'h2F, 17'd9,     16'h0004, 1'b0, ST_OK},
        '{8'd0,   8'h24, 17'd5,     16'h0002, 1'b1, ST_BAD_LENGTH},
        '{8'd0,   8'h2C, 17'd8,     16'hFFFF, 1'b1, ST_BAD_LENGTH},
        '{8'd4,   8'h3B, 17'd12,    16'h0000, 1'b0, ST_OK},
        '{8'd255, 8'h3F, 17'd260,   16'h0000, 1'b0, ST_OK},
        '{8'd255, 8'h3F, 17'd6,     16'hFFFF, 1'b1, ST_TRUNCATED},
        '{8'd255, 8'h3D, 17'd259,   16'h0000, 1'b1, ST_TRUNCATED},
        '{8'd255, 8'h20, 17'd40,    16'h0000, 1'b0, ST_OK},
        '{8'd1,   8'h34, 17'd12,    16'h0007, 1'b0, ST_OK},
        '{8'd1,   8'hFF, 17'd2,     16'h0000, 1'b1, ST_NOT_UNIFIED},
        '{8'd1,   8'h33, 17'd3,     16'h0000, 1'b0, ST_OK}
    };

    dtls_unified_header_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("[dtls_unified_header_parser] ERROR");
        $finish;
    end

    function automatic void field_offsets(input logic [7:0] flags, output int seq_at,
                                          output int seq_w, output int len_at,
                                          output int hdr_len);
        seq_at  = 1 + (flags[CID_BIT] ? int'(cid_cfg) : 0);
        seq_w   = flags[SEQ16_BIT] ? 2 : 1;
        len_at  = seq_at + seq_w;
        hdr_len = len_at + (flags[LEN_BIT] ? 2 : 0);
    endfunction

    // Tracks one accepted byte; returns 1 with the decoded header on the last byte
    function automatic bit parse_byte(input byte_beat_t beat, output result_beat_t hdr);
        int          seq_at;
        int          seq_w;
        int          len_at;
        int          hdr_len;
        int          pos;
        int          total;
        logic [15:0] length;
        status_t     st;
        pos = dg_count;
        hdr = '0;
        if (pos == 0)
            dg_flags = beat.data_byte;
        else
        begin
            field_offsets(dg_flags, seq_at, seq_w, len_at, hdr_len);
            if (pos >= seq_at && pos < seq_at + seq_w)
                seq_sr = {seq_sr[7:0], beat.data_byte};
            if (dg_flags[LEN_BIT] && pos >= len_at && pos < len_at + 2)
                len_sr = {len_sr[7:0], beat.data_byte};
        end
        if (dg_count != COUNT_MAX)
            dg_count = dg_count + 16'd1;
        if (!beat.last_byte)
            return 1'b0;
        field_offsets(dg_flags, seq_at, seq_w, len_at, hdr_len);
        total  = dg_count;
        length = '0;
        st     = ST_OK;
        if ((dg_flags & FIXED_MASK) != FIXED_VAL)
            st = ST_NOT_UNIFIED;
        else if (dg_flags[CID_BIT] && cid_cfg == 8'd0)
            st = ST_CID_UNKNOWN;
        else if (total < hdr_len)
            st = ST_TRUNCATED;
        else if (dg_flags[LEN_BIT])
        begin
            length = len_sr;
            if (int'(length) > total - hdr_len)
                st = ST_BAD_LENGTH;
        end
        else
            length = 16'(total - hdr_len);
        hdr.status = st;
        if (st == ST_OK)
        begin
            hdr.has_cid         = dg_flags[CID_BIT];
            hdr.seq_is_16bit    = dg_flags[SEQ16_BIT];
            hdr.has_length      = dg_flags[LEN_BIT];
            hdr.epoch_low_bits  = dg_flags[1:0];
            hdr.cid_length_out  = dg_flags[CID_BIT] ? cid_cfg : 8'd0;
            hdr.seq_number      = seq_sr;
            hdr.record_length   = length;
            hdr.payload_offset  = 9'(hdr_len);
        end
        dg_count = '0;
        dg_flags = '0;
        seq_sr   = '0;
        len_sr   = '0;
        return 1'b1;
    endfunction

    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] exp);
        if (mismatches < 200)
            $display("mismatch: %s got 0x%0h expected 0x%0h", what, got, exp);
        mismatches++;
    endtask

    task automatic check_header(input result_beat_t got, input result_beat_t exp);
        if (got.status !== exp.status)
            log_mismatch("status", 32'(got.status), 32'(exp.status));
        if (got.has_cid !== exp.has_cid)
            log_mismatch("has_cid", 32'(got.has_cid), 32'(exp.has_cid));
        if (got.seq_is_16bit !== exp.seq_is_16bit)
            log_mismatch("seq_is_16bit", 32'(got.seq_is_16bit), 32'(exp.seq_is_16bit));
        if (got.has_length !== exp.has_length)
            log_mismatch("has_length", 32'(got.has_length), 32'(exp.has_length));
        if (got.epoch_low_bits !== exp.epoch_low_bits)
            log_mismatch("epoch_low_bits", 32'(got.epoch_low_bits), 32'(exp.epoch_low_bits));
        if (got.cid_length_out !== exp.cid_length_out)
            log_mismatch("cid_length_out", 32'(got.cid_length_out), 32'(exp.cid_length_out));
        if (got.seq_number !== exp.seq_number)
            log_mismatch("seq_number", 32'(got.seq_number), 32'(exp.seq_number));
        if (got.record_length !== exp.record_length)
            log_mismatch("record_length", 32'(got.record_length), 32'(exp.record_length));
        if (got.payload_offset !== exp.payload_offset)
            log_mismatch("payload_offset", 32'(got.payload_offset), 32'(exp.payload_offset));
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last, input bit typed,
                             input status_t st);
        result_beat_t hdr;
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 23)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= '{data_byte: b, last_byte: last};
        do
            @(posedge clk);
        while (!byte_ready);
        phase_bytes++;
        if (parse_byte(byte_data, hdr))
        begin
            if (typed)
            begin
                hdr        = '0;
                hdr.status = st;
            end
            pending_headers.push_back(hdr);
            phase_headers++;
        end
    endtask

    task automatic send_datagram(input logic [7:0] flags, input int nbytes,
                                 input logic [15:0] lenval, input bit typed,
                                 input status_t st);
        int         seq_at;
        int         seq_w;
        int         len_at;
        int         hdr_len;
        logic [7:0] b;
        field_offsets(flags, seq_at, seq_w, len_at, hdr_len);
        for (int pos = 0; pos < nbytes; pos++)
        begin
            if (pos == 0)
                b = flags;
            else if (flags[LEN_BIT] && pos == len_at)
                b = lenval[15:8];
            else if (flags[LEN_BIT] && pos == len_at + 1)
                b = lenval[7:0];
            else
                b = 8'($urandom);
            push_byte(b, pos == nbytes - 1, typed, st);
        end
    endtask

    // Mostly well-formed headers; some truncated, some random noise
    task automatic send_random_datagram();
        int          seq_at;
        int          seq_w;
        int          len_at;
        int          hdr_len;
        int          nbytes;
        int          extra;
        int          kind;
        int          pick;
        logic [7:0]  flags;
        logic [15:0] lenval;
        kind   = $urandom_range(0, 99);
        flags  = {3'b001, 5'($urandom)};
        lenval = 16'($urandom);
        if (cid_cfg == 8'd0 && $urandom_range(0, 3) != 0)
            flags[CID_BIT] = 1'b0;
        field_offsets(flags, seq_at, seq_w, len_at, hdr_len);
        if (kind < 75)
        begin
            extra  = $urandom_range(0, 12);
            nbytes = hdr_len + extra;
            pick   = $urandom_range(0, 9);
            if (pick < 6)
                lenval = 16'($urandom_range(0, extra));
            else if (pick == 6)
                lenval = 16'(extra);
            else if (pick < 9)
                lenval = 16'(extra + $urandom_range(1, 3));
        end
        else if (kind < 88)
            nbytes = $urandom_range(1, hdr_len - 1);
        else
        begin
            flags  = 8'($urandom);
            nbytes = $urandom_range(1, 8);
        end
        send_datagram(flags, nbytes, lenval, 1'b0, ST_OK);
    endtask

    // Sender pauses until every pending header has come out
    task automatic settle();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending_headers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cid(input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(REG_CID_LENGTH) << REG_LSB;
        pwdata  <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cid_cfg = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        result_ready = 1'b0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_left    = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= quiet || ($urandom_range(0, 99) >= 23);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (pending_headers.size() == 0)
                    log_mismatch("result beat with nothing pending", 32'd0, 32'd0);
                else
                    check_header(result_data, pending_headers.pop_front());
            end
        end
    end

    initial
    begin
        logic [7:0] next_cid;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        byte_valid    = 1'b0;
        byte_data     = '0;
        cid_cfg       = '0;
        dg_count      = '0;
        dg_flags      = '0;
        seq_sr        = '0;
        len_sr        = '0;
        mismatches    = 0;
        quiet         = 1'b0;
        hold_off_req  = 1'b0;
        phase_bytes   = 0;
        phase_headers = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].cid != cid_cfg)
            begin
                settle();
                write_cid(plan[i].cid);
            end
            send_datagram(plan[i].flags, int'(plan[i].nbytes), plan[i].lenval,
                          plan[i].typed, plan[i].st);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            case (ph)
                0: next_cid = 8'd0;
                1: next_cid = 8'd1;
                2: next_cid = 8'd64;
                3: next_cid = 8'($urandom_range(2, 16));
                4: next_cid = 8'($urandom);
                default: next_cid = 8'd3;
            endcase
            write_cid(next_cid);
            quiet = (ph == 3);
            if (ph == 1)
            begin
                @(posedge clk);
                hold_off_req = 1'b1;
            end
            phase_bytes   = 0;
            phase_headers = 0;
            while (phase_bytes < 60 || phase_headers < 4)
                send_random_datagram();
        end
        quiet = 1'b0;
        settle();

        if (mismatches == 0)
            $display("[dtls_unified_header_parser] OK");
        else
            $display("[dtls_unified_header_parser] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/dtls_uhp_pkg.sv
rtl/core/dtls_uhp_regs.sv
rtl/core/dtls_uhp_track.sv
rtl/core/dtls_uhp_check.sv
rtl/core/dtls_unified_header_parser.sv
tb/tb_dtls_unified_header_parser.sv
